/* rtl/usfb_pkg.sv */
// shared types and constants for the uart to spi fram bridge
package usfb_pkg;

    localparam int READ_BLOCK_DEF  = 32;
    localparam int WRITE_BLOCK_DEF = 16;
    localparam int STORE_IDX_W     = 4;

    // input word kinds
    localparam logic [1:0] MODE_HOST = 2'd0;
    localparam logic [1:0] MODE_FRAM = 2'd1;
    localparam logic [1:0] MODE_DONE = 2'd2;

    // output ports
    localparam logic [1:0] PORT_HOST   = 2'd0;
    localparam logic [1:0] PORT_SPI    = 2'd1;
    localparam logic [1:0] PORT_RDREQ  = 2'd2;
    localparam logic [1:0] PORT_DESEL  = 2'd3;

    // spi opcodes
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRSR  = 8'h01;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] ADDR_HI_MASK = 8'h1f;

    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_O = 8'h4f;

    // output segments, emitted in index order
    localparam int SEG_N       = 13;
    localparam int SEG_DATA    = 0;
    localparam int SEG_REQ     = 1;
    localparam int SEG_DSUM    = 2;
    localparam int SEG_WRSR    = 3;
    localparam int SEG_CADDR   = 4;
    localparam int SEG_BODY    = 5;
    localparam int SEG_DESEL   = 6;
    localparam int SEG_OK      = 7;
    localparam int SEG_SIZEREQ = 8;
    localparam int SEG_WREN    = 9;
    localparam int SEG_SIZE    = 10;
    localparam int SEG_TS      = 11;
    localparam int SEG_LETTER  = 12;

    typedef struct packed {
        logic [SEG_N-1:0] segs;
        logic [7:0]       data;
        logic [7:0]       bsum;
        logic [7:0]       tsum;
        logic [7:0]       op;
        logic [7:0]       letter;
        logic [15:0]      addr;
        logic [5:0]       size;
        logic [4:0]       body_cnt;
        logic             body_zero;
    } job_t;

    typedef struct packed {
        logic                   en;
        logic [STORE_IDX_W-1:0] idx;
        logic [7:0]             data;
    } store_wr_t;

endpackage

/* rtl/uart_to_spi_fram_bridge.sv */
// top level of the host command bridge to an spi fram
//
// input channel (in_valid / in_stall): one word per event, mode 0 host byte,
// mode 1 byte read back from the fram, mode 2 spi transaction done; data
// carries the byte for modes 0 and 1
// output channel (out_valid / out_stall): one word per cycle while not
// stalled, toward the host uart (port 0), the spi shifter (port 1), an spi
// read-one-byte request (port 2) or spi deselect (port 3); last marks the
// final word caused by one input word
// a parser accepts a word and queues a job when the word produces output;
// the emitter expands each job at one word per cycle while the output is
// not stalled; a job passes through the queue, the emitter's job register
// and the output register, and an input word yields up to 24 output words
// input words are taken back to back while the two-entry job queue has
// room; during write data collection the parser also waits for the queue
// to drain and the emitter to go idle before it writes the write block store
// reset clears all protocol state to idle and empties queue and output
// a stalled output word holds; the emitter and then the queue fill and
// in_stall rises, no words are dropped
module uart_to_spi_fram_bridge
    import usfb_pkg::*;
#(
    parameter int READ_BLOCK  = READ_BLOCK_DEF,
    parameter int WRITE_BLOCK = WRITE_BLOCK_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [7:0] data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] port,
    output logic [7:0] byte_res,
    output logic       last
);

    // parser to queue
    logic      push;
    job_t      push_job;
    // queue to emitter
    job_t      head;
    logic      q_empty, q_full, pop;
    // emitter status and write store port
    logic      back_busy;
    store_wr_t store_wr;

    usfb_front #(
        .READ_BLOCK  (READ_BLOCK),
        .WRITE_BLOCK (WRITE_BLOCK)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .data      (data),
        .q_full    (q_full),
        .back_busy (back_busy),
        .push      (push),
        .job       (push_job),
        .store_wr  (store_wr)
    );

    usfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    usfb_back #(
        .WRITE_BLOCK (WRITE_BLOCK)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .busy      (back_busy),
        .store_wr  (store_wr),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .port      (port),
        .byte_res  (byte_res),
        .last      (last)
    );

endmodule

/* rtl/usfb_front.sv */
// command parser: accepts words, updates protocol state, queues output jobs
module usfb_front
    import usfb_pkg::*;
#(
    parameter int READ_BLOCK  = READ_BLOCK_DEF,
    parameter int WRITE_BLOCK = WRITE_BLOCK_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [7:0] data,
    input  logic       q_full,
    input  logic       back_busy,
    output logic       push,
    output job_t       job,
    output store_wr_t  store_wr
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_HEADER   = 4'd1;
    localparam logic [3:0] PH_READ     = 4'd2;
    localparam logic [3:0] PH_WDATA    = 4'd3;
    localparam logic [3:0] PH_WSUM     = 4'd4;
    localparam logic [3:0] PH_E_WRSR   = 4'd5;
    localparam logic [3:0] PH_E_WREN   = 4'd6;
    localparam logic [3:0] PH_E_DATA   = 4'd7;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_ERASE = 2'd2;

    logic [3:0]  phase_reg, phase_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [2:0]  hc_reg, hc_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] rem_reg, rem_next;
    logic [5:0]  bl_reg, bl_next;
    logic [4:0]  bi_reg, bi_next;
    logic [7:0]  ts_reg, ts_next;
    logic [7:0]  bs_reg, bs_next;

    logic        accept;
    logic        gen;

    assign in_stall = q_full || (phase_reg == PH_WDATA && back_busy);
    assign accept   = in_valid && !in_stall;
    assign push     = accept && gen;

    function automatic logic [5:0] rd_len(input logic [15:0] r);
        return (r < 16'(READ_BLOCK)) ? r[5:0] : 6'(READ_BLOCK);
    endfunction

    function automatic logic [5:0] wr_len(input logic [15:0] r);
        return (r < 16'(WRITE_BLOCK)) ? r[5:0] : 6'(WRITE_BLOCK);
    endfunction

    always_comb
    begin
        logic [15:0] r;
        logic [5:0]  n;
        logic [2:0]  hc1;
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        hc_next    = hc_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        bl_next    = bl_reg;
        bi_next    = bi_reg;
        ts_next    = ts_reg;
        bs_next    = bs_reg;
        job        = '0;
        store_wr   = '0;
        r          = '0;
        n          = '0;
        hc1        = hc_reg + 3'd1;
        unique case (mode)
            MODE_HOST:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (data == CH_P)
                        begin
                            job.segs[SEG_LETTER] = 1'b1;
                            job.letter = CH_P;
                        end
                        else if (data == CH_R || data == CH_W || data == CH_E)
                        begin
                            cmd_next   = (data == CH_R) ? CMD_READ :
                                         ((data == CH_W) ? CMD_WRITE : CMD_ERASE);
                            hc_next    = '0;
                            addr_next  = '0;
                            rem_next   = '0;
                            phase_next = PH_HEADER;
                        end
                    end
                    PH_HEADER:
                    begin
                        if (hc_reg < 3'd2)
                            addr_next = {addr_reg[7:0], data};
                        else
                            rem_next = {rem_reg[7:0], data};
                        hc_next = hc1;
                        if (hc1 >= 3'd4)
                        begin
                            hc_next = '0;
                            ts_next = '0;
                            r       = rem_next;
                            if (cmd_reg == CMD_READ)
                            begin
                                if (r == '0)
                                begin
                                    job.segs[SEG_TS]     = 1'b1;
                                    job.segs[SEG_LETTER] = 1'b1;
                                    job.tsum   = '0;
                                    job.letter = CH_R;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    n = rd_len(r);
                                    bl_next = n;
                                    bs_next = '0;
                                    job.segs[SEG_CADDR]   = 1'b1;
                                    job.segs[SEG_SIZEREQ] = 1'b1;
                                    job.op   = OP_READ;
                                    job.addr = addr_next;
                                    job.size = n;
                                    phase_next = PH_READ;
                                end
                            end
                            else
                            begin
                                job.segs[SEG_WRSR] = 1'b1;
                                if (cmd_reg == CMD_WRITE)
                                begin
                                    if (r == '0)
                                    begin
                                        job.segs[SEG_TS]     = 1'b1;
                                        job.segs[SEG_LETTER] = 1'b1;
                                        job.tsum   = '0;
                                        job.letter = CH_W;
                                        phase_next = PH_IDLE;
                                    end
                                    else
                                    begin
                                        n = wr_len(r);
                                        bl_next = n;
                                        bi_next = '0;
                                        bs_next = '0;
                                        job.segs[SEG_WREN] = 1'b1;
                                        job.segs[SEG_SIZE] = 1'b1;
                                        job.size = n;
                                        phase_next = PH_WDATA;
                                    end
                                end
                                else
                                    phase_next = PH_E_WRSR;
                            end
                        end
                    end
                    PH_WDATA:
                    begin
                        store_wr.en   = 1'b1;
                        store_wr.idx  = bi_reg[STORE_IDX_W-1:0];
                        store_wr.data = data;
                        bi_next = bi_reg + 5'd1;
                        ts_next = ts_reg + data;
                        bs_next = bs_reg + data;
                        if (bl_reg != '0)
                            bl_next = bl_reg - 6'd1;
                        if (bl_next == '0)
                            phase_next = PH_WSUM;
                    end
                    PH_WSUM:
                    begin
                        if (data != bs_reg)
                        begin
                            job.segs[SEG_LETTER] = 1'b1;
                            job.letter = CH_C;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            job.segs[SEG_CADDR] = 1'b1;
                            job.segs[SEG_BODY]  = 1'b1;
                            job.segs[SEG_DESEL] = 1'b1;
                            job.segs[SEG_OK]    = 1'b1;
                            job.op       = OP_WRITE;
                            job.addr     = addr_reg;
                            job.body_cnt = (bi_reg > 5'd16) ? 5'd16 : bi_reg;
                            addr_next = addr_reg + 16'(bi_reg);
                            rem_next  = rem_reg - 16'(bi_reg);
                            r = rem_next;
                            if (r == '0)
                            begin
                                job.segs[SEG_TS]     = 1'b1;
                                job.segs[SEG_LETTER] = 1'b1;
                                job.tsum   = ts_reg;
                                job.letter = CH_W;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                n = wr_len(r);
                                bl_next = n;
                                bi_next = '0;
                                bs_next = '0;
                                job.segs[SEG_WREN] = 1'b1;
                                job.segs[SEG_SIZE] = 1'b1;
                                job.size = n;
                                phase_next = PH_WDATA;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_FRAM:
            begin
                if (phase_reg == PH_READ)
                begin
                    job.segs[SEG_DATA] = 1'b1;
                    job.data = data;
                    ts_next   = ts_reg + data;
                    bs_next   = bs_reg + data;
                    addr_next = addr_reg + 16'd1;
                    rem_next  = rem_reg - 16'd1;
                    if (bl_reg != '0)
                        bl_next = bl_reg - 6'd1;
                    if (bl_next != '0)
                        job.segs[SEG_REQ] = 1'b1;
                    else
                    begin
                        job.segs[SEG_DSUM] = 1'b1;
                        job.bsum = bs_next;
                        r = rem_next;
                        if (r != '0)
                        begin
                            n = rd_len(r);
                            bl_next = n;
                            bs_next = '0;
                            job.segs[SEG_CADDR]   = 1'b1;
                            job.segs[SEG_SIZEREQ] = 1'b1;
                            job.op   = OP_READ;
                            job.addr = addr_next;
                            job.size = n;
                        end
                        else
                        begin
                            job.segs[SEG_TS]     = 1'b1;
                            job.segs[SEG_LETTER] = 1'b1;
                            job.tsum   = ts_next;
                            job.letter = CH_R;
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            MODE_DONE:
            begin
                if (phase_reg == PH_E_WRSR || phase_reg == PH_E_DATA)
                begin
                    if (rem_reg == '0)
                    begin
                        job.segs[SEG_LETTER] = 1'b1;
                        job.letter = CH_E;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        job.segs[SEG_WREN] = 1'b1;
                        phase_next = PH_E_WREN;
                    end
                end
                else if (phase_reg == PH_E_WREN)
                begin
                    n = wr_len(rem_reg);
                    job.segs[SEG_CADDR] = 1'b1;
                    job.segs[SEG_BODY]  = 1'b1;
                    job.segs[SEG_DESEL] = 1'b1;
                    job.op        = OP_WRITE;
                    job.addr      = addr_reg;
                    job.body_cnt  = n[4:0];
                    job.body_zero = 1'b1;
                    addr_next = addr_reg + 16'(n);
                    rem_next  = rem_reg - 16'(n);
                    phase_next = PH_E_DATA;
                end
            end
            default:
            begin
            end
        endcase
        gen = (job.segs != '0);
        if (!accept)
            store_wr.en = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= '0;
            hc_reg    <= '0;
            addr_reg  <= '0;
            rem_reg   <= '0;
            bl_reg    <= '0;
            bi_reg    <= '0;
            ts_reg    <= '0;
            bs_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            hc_reg    <= hc_next;
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
            bl_reg    <= bl_next;
            bi_reg    <= bi_next;
            ts_reg    <= ts_next;
            bs_reg    <= bs_next;
        end
    end

endmodule

/* rtl/usfb_queue.sv */
// two-entry job queue between parser and emitter
module usfb_queue
    import usfb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* rtl/usfb_back.sv */
// emitter: expands queued jobs into output words, one per cycle while not stalled, holds write store
module usfb_back
    import usfb_pkg::*;
#(
    parameter int WRITE_BLOCK = WRITE_BLOCK_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  logic       q_empty,
    output logic       pop,
    output logic       busy,
    input  store_wr_t  store_wr,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] port,
    output logic [7:0] byte_res,
    output logic       last
);

    localparam int AW = (WRITE_BLOCK > 1) ? $clog2(WRITE_BLOCK) : 1;

    logic [7:0]       store_reg [2**AW];
    job_t             job_reg;
    logic [SEG_N-1:0] mask_reg, mask_next;
    logic [4:0]       step_reg;
    logic             active, load;
    logic [1:0]       e_port;
    logic [7:0]       e_byte;
    logic             seg_end;
    logic [3:0]       seg;

    logic             vld_reg;
    logic [1:0]       port_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;

    assign active = (mask_reg != '0);
    assign pop    = !active && !q_empty;
    assign busy   = active || !q_empty;
    assign load   = active && (!vld_reg || !out_stall);

    always_comb
    begin
        seg = '0;
        for (int i = SEG_N - 1; i >= 0; i--)
            if (mask_reg[i])
                seg = 4'(i);
    end

    always_comb
    begin
        e_port  = PORT_HOST;
        e_byte  = '0;
        seg_end = 1'b1;
        unique case (seg)
            4'(SEG_DATA):    e_byte = job_reg.data;
            4'(SEG_REQ):     e_port = PORT_RDREQ;
            4'(SEG_DSUM):
            begin
                seg_end = (step_reg == 5'd1);
                if (step_reg == 5'd0)
                    e_port = PORT_DESEL;
                else
                    e_byte = job_reg.bsum;
            end
            4'(SEG_WRSR):
            begin
                seg_end = (step_reg == 5'd2);
                e_port  = (step_reg == 5'd2) ? PORT_DESEL : PORT_SPI;
                e_byte  = (step_reg == 5'd0) ? OP_WRSR : 8'h00;
            end
            4'(SEG_CADDR):
            begin
                seg_end = (step_reg == 5'd2);
                e_port  = PORT_SPI;
                if (step_reg == 5'd0)
                    e_byte = job_reg.op;
                else if (step_reg == 5'd1)
                    e_byte = job_reg.addr[15:8] & ADDR_HI_MASK;
                else
                    e_byte = job_reg.addr[7:0];
            end
            4'(SEG_BODY):
            begin
                seg_end = (step_reg == job_reg.body_cnt - 5'd1);
                e_port  = PORT_SPI;
                e_byte  = job_reg.body_zero ? 8'h00 : store_reg[step_reg[AW-1:0]];
            end
            4'(SEG_DESEL):   e_port = PORT_DESEL;
            4'(SEG_OK):      e_byte = CH_O;
            4'(SEG_SIZEREQ):
            begin
                seg_end = (step_reg == 5'd1);
                if (step_reg == 5'd0)
                    e_byte = 8'(job_reg.size);
                else
                    e_port = PORT_RDREQ;
            end
            4'(SEG_WREN):
            begin
                seg_end = (step_reg == 5'd1);
                e_port  = (step_reg == 5'd0) ? PORT_SPI : PORT_DESEL;
                e_byte  = (step_reg == 5'd0) ? OP_WREN : 8'h00;
            end
            4'(SEG_SIZE):    e_byte = 8'(job_reg.size);
            4'(SEG_TS):      e_byte = job_reg.tsum;
            4'(SEG_LETTER):  e_byte = job_reg.letter;
            default:
            begin
            end
        endcase
        mask_next = mask_reg;
        if (seg_end)
            mask_next[seg] = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
            store_reg[store_wr.idx[AW-1:0]] <= store_wr.data;
        if (pop)
            job_reg <= head;
        if (load)
        begin
            port_reg <= e_port;
            byte_reg <= e_byte;
            last_reg <= (mask_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            step_reg <= '0;
            vld_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mask_reg <= head.segs;
                step_reg <= '0;
            end
            else if (load)
            begin
                mask_reg <= mask_next;
                step_reg <= seg_end ? 5'd0 : step_reg + 5'd1;
            end
            if (load)
                vld_reg <= 1'b1;
            else if (!out_stall)
                vld_reg <= 1'b0;
        end
    end

    assign out_valid = vld_reg;
    assign port      = port_reg;
    assign byte_res  = byte_reg;
    assign last      = last_reg;

endmodule

/* rtl/usfb_checker.sv */
// port-level checks for the bridge, bound to the top level
module usfb_checker
    import usfb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] mode,
    input logic [7:0] data,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] port,
    input logic [7:0] byte_res,
    input logic       last
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(port) && $stable(byte_res)
            && $stable(last))
        else $error("stalled output word changed");

    // request and deselect words carry no byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (port == PORT_RDREQ || port == PORT_DESEL) |-> byte_res == 8'h00)
        else $error("nonzero byte on request or deselect");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid after reset");

endmodule

bind uart_to_spi_fram_bridge usfb_checker u_chk (.*);
